/* hw/rtl/gasp_pkg.sv */
// shared constants, types and codes of the glyph atlas shelf packer
package gasp_pkg;

  localparam int unsigned AtlasWidth      = 1024;
  localparam int unsigned AtlasHeight     = 1024;
  localparam int unsigned AtlasCountDef   = 8;
  localparam int unsigned RowsPerAtlasDef = 16;

  localparam int unsigned GlyphW     = 11;
  localparam int unsigned RowHeightW = 11;
  localparam int unsigned GapW       = 4;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned AtlasIdxW  = 3;
  localparam int unsigned PosW       = 10;
  localparam int unsigned CursorW    = 11;
  localparam int unsigned FillW      = 11;
  localparam int unsigned RowsUsedW  = 5;
  localparam int unsigned RowWordW   = PosW + CursorW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  localparam logic [CursorW-1:0] AtlasWidthC     = CursorW'(AtlasWidth);
  localparam logic [CursorW:0]   AtlasWidthExtC  = (CursorW + 1)'(AtlasWidth);
  localparam logic [FillW-1:0]   AtlasHeightC    = FillW'(AtlasHeight);
  localparam logic [FillW:0]     AtlasHeightExtC = (FillW + 1)'(AtlasHeight);

  localparam logic [RowHeightW-1:0] RowHeightRst = RowHeightW'(64);
  localparam logic [GapW-1:0]       GlyphGapRst  = GapW'(2);

  localparam logic [CfgIdxW-1:0] RegRowHeight = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGlyphGap  = CfgIdxW'(1);

  typedef enum logic [StatusW-1:0] {
    StExisting = 2'd0,
    StNewRow   = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef struct packed {
    logic                 en;
    logic [AtlasIdxW-1:0] atlas;
  } atl_upd_t;

  typedef struct packed {
    logic                 found;
    logic [AtlasIdxW-1:0] atlas;
    logic [RowsUsedW-1:0] rows;
    logic [FillW-1:0]     fill;
  } atl_pick_t;

endpackage

/* hw/rtl/gasp_ram.sv */
// generic single-write, single-read ram with registered read data
module gasp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gasp_atlas_tbl.sv */
// per-atlas row count and fill level, with selection of the atlas that opens a new row
module gasp_atlas_tbl #(
  parameter int unsigned AtlasCount   = gasp_pkg::AtlasCountDef,
  parameter int unsigned RowsPerAtlas = gasp_pkg::RowsPerAtlasDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [gasp_pkg::RowHeightW-1:0]     row_height_i,
  input  logic [gasp_pkg::GapW-1:0]           glyph_gap_i,
  input  logic [gasp_pkg::AtlasIdxW-1:0]      rd_atlas_i,
  output logic [gasp_pkg::RowsUsedW-1:0]      rd_rows_o,
  output gasp_pkg::atl_pick_t                 pick_o,
  input  gasp_pkg::atl_upd_t                  upd_i
);
  import gasp_pkg::*;

  localparam int unsigned AIdxW = (AtlasCount > 1) ? $clog2(AtlasCount) : 1;
  localparam logic [RowsUsedW-1:0] RowsMax = RowsUsedW'(RowsPerAtlas);

  logic [RowsUsedW-1:0] rows_used_q [AtlasCount];
  logic [RowsUsedW-1:0] rows_used_d [AtlasCount];
  logic [FillW-1:0]     fill_q      [AtlasCount];
  logic [FillW-1:0]     fill_d      [AtlasCount];
  logic [AtlasCount-1:0] fits;
  logic [RowsUsedW-1:0] rd_raw;
  logic [AIdxW-1:0]     upd_idx;
  logic [FillW-1:0]     fill_next;

  assign rd_raw    = rows_used_q[rd_atlas_i[AIdxW-1:0]];
  assign rd_rows_o = (rd_raw > RowsMax) ? RowsMax : rd_raw;

  // room for one more row
  always_comb begin
    for (int a = 0; a < AtlasCount; a++) begin
      fits[a] = (rows_used_q[a] < RowsMax) && (fill_q[a] < AtlasHeightC) &&
                (({1'b0, fill_q[a]} + {1'b0, row_height_i}) <= AtlasHeightExtC);
    end
  end

  // lowest atlas wins
  always_comb begin
    pick_o = '0;
    for (int a = 0; a < AtlasCount; a++) begin
      if (fits[a] && !pick_o.found) begin
        pick_o.found = 1'b1;
        pick_o.atlas = AtlasIdxW'(a);
        pick_o.rows  = rows_used_q[a];
        pick_o.fill  = fill_q[a];
      end
    end
  end

  assign upd_idx   = upd_i.atlas[AIdxW-1:0];
  assign fill_next = fill_q[upd_idx] + row_height_i + FillW'(glyph_gap_i);

  always_comb begin
    rows_used_d = rows_used_q;
    fill_d      = fill_q;
    if (upd_i.en) begin
      rows_used_d[upd_idx] = rows_used_q[upd_idx] + RowsUsedW'(1);
      fill_d[upd_idx]      = fill_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AtlasCount; a++) begin
        rows_used_q[a] <= '0;
        fill_q[a]      <= '0;
      end
    end else begin
      rows_used_q <= rows_used_d;
      fill_q      <= fill_d;
    end
  end

endmodule

/* hw/rtl/glyph_atlas_shelf_packer_core.sv */
// Glyph atlas shelf packer: places each glyph width into the first shelf row with room, atlas by
// atlas and row by row, and opens a new row in the first atlas with vertical room when none
// fits. One item is worked on at a time. Row cursors and tops live in a ram with registered
// read data that is read one row per cycle within an atlas. A glyph wider than the atlas skips
// the scan and is reported full. The next item is taken while a result waits on the output,
// and a finished item waits while the output register is still held.
module glyph_atlas_shelf_packer_core #(
  parameter int unsigned AtlasCount   = gasp_pkg::AtlasCountDef,
  parameter int unsigned RowsPerAtlas = gasp_pkg::RowsPerAtlasDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gasp_pkg::InDataW-1:0]      s_axis_tdata,   // glyph_width
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gasp_pkg::OutDataW-1:0]     m_axis_tdata,   // atlas_index, pos_x, pos_y
  output logic [gasp_pkg::StatusW-1:0]      m_axis_tuser,   // status
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gasp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gasp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import gasp_pkg::*;

  localparam int unsigned Slots = AtlasCount * RowsPerAtlas;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [AtlasIdxW-1:0] LastAtlas = AtlasIdxW'(AtlasCount - 1);
  localparam logic [SlotW-1:0]     RowStep   = SlotW'(RowsPerAtlas);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SScan = 4'b0010,
    SNew  = 4'b0100,
    SEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [RowHeightW-1:0] row_height_q, row_height_d;
  logic [GapW-1:0]       glyph_gap_q, glyph_gap_d;

  logic [GlyphW-1:0]    w_q, w_d;
  logic [AtlasIdxW-1:0] a_iss_q, a_iss_d;
  logic [SlotW-1:0]     base_q, base_d;
  logic [RowsUsedW-1:0] r_iss_q, r_iss_d;
  logic                 iss_done_q, iss_done_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [SlotW-1:0]     pend_addr_q, pend_addr_d;
  logic [AtlasIdxW-1:0] pend_atlas_q, pend_atlas_d;

  status_e              res_status_q, res_status_d;
  logic [AtlasIdxW-1:0] res_atlas_q, res_atlas_d;
  logic [PosW-1:0]      res_x_q, res_x_d;
  logic [PosW-1:0]      res_y_q, res_y_d;

  logic                 m_valid_q, m_valid_d;
  status_e              out_status_q, out_status_d;
  logic [AtlasIdxW-1:0] out_atlas_q, out_atlas_d;
  logic [PosW-1:0]      out_x_q, out_x_d;
  logic [PosW-1:0]      out_y_q, out_y_d;

  logic                ram_re, ram_we;
  logic [SlotW-1:0]    ram_raddr, ram_waddr;
  logic [RowWordW-1:0] ram_wdata, ram_rdata;

  logic [RowsUsedW-1:0] tbl_rows;
  atl_pick_t            tbl_pick;
  atl_upd_t             tbl_upd;

  logic [CursorW-1:0] rd_cursor;
  logic [PosW-1:0]    rd_top;
  logic [CursorW:0]   cx_end;
  logic               row_fits;
  logic [CursorW-1:0] cursor_next;
  logic [CursorW-1:0] new_cursor;
  logic               issue;
  logic [SlotW-1:0]   new_addr;
  logic               in_acc;
  logic               out_free;

  gasp_ram #(
    .Width (RowWordW),
    .Depth (Slots)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gasp_atlas_tbl #(
    .AtlasCount   (AtlasCount),
    .RowsPerAtlas (RowsPerAtlas)
  ) u_atlas_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_height_i (row_height_q),
    .glyph_gap_i  (glyph_gap_q),
    .rd_atlas_i   (a_iss_q),
    .rd_rows_o    (tbl_rows),
    .pick_o       (tbl_pick),
    .upd_i        (tbl_upd)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == SIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign rd_cursor   = ram_rdata[CursorW-1:0];
  assign rd_top      = ram_rdata[RowWordW-1:CursorW];
  assign cx_end      = {1'b0, rd_cursor} + {1'b0, w_q};
  assign row_fits    = pend_vld_q && (rd_cursor < AtlasWidthC) && (cx_end <= AtlasWidthExtC);
  assign cursor_next = rd_cursor + w_q + CursorW'(glyph_gap_q);
  assign new_cursor  = w_q + CursorW'(glyph_gap_q);
  assign issue       = (state_q == SScan) && !iss_done_q && (r_iss_q < tbl_rows);
  assign ram_re      = issue && !row_fits;
  assign ram_raddr   = base_q + SlotW'(r_iss_q);
  assign new_addr    = SlotW'(32'(tbl_pick.atlas) * RowsPerAtlas + 32'(tbl_pick.rows));

  always_comb begin
    row_height_d = row_height_q;
    glyph_gap_d  = glyph_gap_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRowHeight: row_height_d = cfg_data_i[RowHeightW-1:0];
        RegGlyphGap:  glyph_gap_d  = cfg_data_i[GapW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    w_d          = w_q;
    a_iss_d      = a_iss_q;
    base_d       = base_q;
    r_iss_d      = r_iss_q;
    iss_done_d   = iss_done_q;
    pend_vld_d   = pend_vld_q;
    pend_addr_d  = pend_addr_q;
    pend_atlas_d = pend_atlas_q;
    res_status_d = res_status_q;
    res_atlas_d  = res_atlas_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = {rd_top, cursor_next};
    tbl_upd      = '0;

    m_valid_d    = m_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_atlas_d  = out_atlas_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;

    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          w_d        = s_axis_tdata[GlyphW-1:0];
          a_iss_d    = '0;
          base_d     = '0;
          r_iss_d    = '0;
          iss_done_d = 1'b0;
          pend_vld_d = 1'b0;
          if (s_axis_tdata[GlyphW-1:0] > AtlasWidthC) begin
            res_status_d = StFull;
            res_atlas_d  = '0;
            res_x_d      = '0;
            res_y_d      = '0;
            state_d      = SEmit;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (row_fits) begin
          ram_we       = 1'b1;
          pend_vld_d   = 1'b0;
          res_status_d = StExisting;
          res_atlas_d  = pend_atlas_q;
          res_x_d      = rd_cursor[PosW-1:0];
          res_y_d      = rd_top;
          state_d      = SEmit;
        end else begin
          pend_vld_d   = issue;
          pend_addr_d  = ram_raddr;
          pend_atlas_d = a_iss_q;
          if (issue) begin
            r_iss_d = r_iss_q + RowsUsedW'(1);
          end else if (!iss_done_q) begin
            if (a_iss_q == LastAtlas) begin
              iss_done_d = 1'b1;
            end else begin
              a_iss_d = a_iss_q + AtlasIdxW'(1);
              base_d  = base_q + RowStep;
              r_iss_d = '0;
            end
          end
          if (iss_done_q && !pend_vld_q) begin
            state_d = SNew;
          end
        end
      end
      SNew: begin
        if (tbl_pick.found) begin
          ram_we        = 1'b1;
          ram_waddr     = new_addr;
          ram_wdata     = {tbl_pick.fill[PosW-1:0], new_cursor};
          tbl_upd.en    = 1'b1;
          tbl_upd.atlas = tbl_pick.atlas;
          res_status_d  = StNewRow;
          res_atlas_d   = tbl_pick.atlas;
          res_x_d       = '0;
          res_y_d       = tbl_pick.fill[PosW-1:0];
        end else begin
          res_status_d = StFull;
          res_atlas_d  = '0;
          res_x_d      = '0;
          res_y_d      = '0;
        end
        state_d = SEmit;
      end
      SEmit: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_atlas_d  = res_atlas_q;
          out_x_d      = res_x_q;
          out_y_d      = res_y_q;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      row_height_q <= RowHeightRst;
      glyph_gap_q  <= GlyphGapRst;
      iss_done_q   <= 1'b0;
      pend_vld_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_height_q <= row_height_d;
      glyph_gap_q  <= glyph_gap_d;
      iss_done_q   <= iss_done_d;
      pend_vld_q   <= pend_vld_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    a_iss_q      <= a_iss_d;
    base_q       <= base_d;
    r_iss_q      <= r_iss_d;
    pend_addr_q  <= pend_addr_d;
    pend_atlas_q <= pend_atlas_d;
    res_status_q <= res_status_d;
    res_atlas_q  <= res_atlas_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    out_status_q <= out_status_d;
    out_atlas_q  <= out_atlas_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_y_q, out_x_q, out_atlas_q};

endmodule

/* hw/rtl/gasp_checker.sv */
// port-level checks of the glyph atlas shelf packer, bound to the top level
module gasp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gasp_pkg::OutDataW-1:0]     m_axis_tdata,
  input logic [gasp_pkg::StatusW-1:0]      m_axis_tuser
);
  import gasp_pkg::*;

  // one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while another is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
                                          $stable(m_axis_tuser)))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == StExisting || m_axis_tuser == StNewRow ||
                       m_axis_tuser == StFull))
    else $error("status code out of range");

  // full result carries no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StFull) |-> (m_axis_tdata == '0))
    else $error("full result with non-zero fields");

  // new row starts at the left edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StNewRow) |-> (m_axis_tdata[AtlasIdxW +: PosW] == '0))
    else $error("new row glyph not at column zero");

endmodule

bind glyph_atlas_shelf_packer_core gasp_checker u_gasp_checker (.*);

/* tb/tb_glyph_atlas_shelf_packer_core.sv */
// self-checking testbench for the glyph atlas shelf packer core
`timescale 1ns / 1ps

module tb_glyph_atlas_shelf_packer_core;
  import gasp_pkg::*;

  localparam int unsigned AtlasCnt    = AtlasCountDef;
  localparam int unsigned RowsPer     = RowsPerAtlasDef;
  localparam int unsigned ShelfSlots  = AtlasCnt * RowsPer;
  localparam int unsigned PhaseCnt    = 6;
  localparam int unsigned RandomTotal = 1900;
  localparam int unsigned CalmTail    = 150;
  localparam int unsigned HoldAt      = 100;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned LogCap      = 50;

  // indexes with no register behind them
  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);

  typedef enum logic {JobGlyph, JobCfg} job_kind_e;

  typedef struct {
    job_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] value;
    logic                idle_ok;
  } job_t;

  typedef struct {
    status_e              st;
    logic [AtlasIdxW-1:0] atlas;
    logic [PosW-1:0]      x;
    logic [PosW-1:0]      y;
  } placement_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [StatusW-1:0]    m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;

  // shelf state as the block should hold it
  logic [CursorW-1:0]    shelf_cursor [ShelfSlots];
  logic [PosW-1:0]       shelf_top    [ShelfSlots];
  logic [RowsUsedW-1:0]  shelves_open [AtlasCnt];
  logic [FillW-1:0]      atlas_fill   [AtlasCnt];
  logic [RowHeightW-1:0] cur_row_height;
  logic [GapW-1:0]       cur_gap;

  job_t        glyph_jobs[$];
  placement_t  placements_due[$];
  int unsigned glyphs_queued = 0;
  int unsigned glyphs_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned sender_gap    = 0;
  logic        gaps_on       = 1'b1;
  logic        calm          = 1'b0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;
  int unsigned stall_left    = 0;

  glyph_atlas_shelf_packer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic placement_t place_glyph(input logic [GlyphW-1:0] w);
    placement_t  p;
    int unsigned n;
    int unsigned k;
    int unsigned cx;
    int unsigned fill;
    p.st    = StFull;
    p.atlas = '0;
    p.x     = '0;
    p.y     = '0;
    if (32'(w) > AtlasWidth) return p;
    // first fit over the open shelves
    for (int unsigned a = 0; a < AtlasCnt; a++) begin
      n = 32'(shelves_open[a]);
      if (n > RowsPer) n = RowsPer;
      for (int unsigned r = 0; r < n; r++) begin
        k  = a * RowsPer + r;
        cx = 32'(shelf_cursor[k]);
        if (cx < AtlasWidth && cx + 32'(w) <= AtlasWidth) begin
          shelf_cursor[k] = CursorW'(cx + 32'(w) + 32'(cur_gap));
          p.st    = StExisting;
          p.atlas = AtlasIdxW'(a);
          p.x     = PosW'(cx);
          p.y     = shelf_top[k];
          return p;
        end
      end
    end
    // open a shelf in the first atlas with room
    for (int unsigned a = 0; a < AtlasCnt; a++) begin
      fill = 32'(atlas_fill[a]);
      n    = 32'(shelves_open[a]);
      if (n < RowsPer && fill < AtlasHeight && fill + 32'(cur_row_height) <= AtlasHeight) begin
        k = a * RowsPer + n;
        shelf_top[k]    = PosW'(fill);
        shelf_cursor[k] = CursorW'(32'(w) + 32'(cur_gap));
        shelves_open[a] = RowsUsedW'(n + 1);
        atlas_fill[a]   = FillW'(fill + 32'(cur_row_height) + 32'(cur_gap));
        p.st    = StNewRow;
        p.atlas = AtlasIdxW'(a);
        p.y     = PosW'(fill);
        return p;
      end
    end
    return p;
  endfunction

  function automatic logic [GlyphW-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return GlyphW'($urandom_range(0, 48));
    if (r < 80) return GlyphW'($urandom_range(49, 1024));
    if (r < 93) return GlyphW'($urandom_range(1000, 1024));
    return GlyphW'($urandom_range(1025, 2047));
  endfunction

  task automatic queue_glyph(input logic [GlyphW-1:0] w, input logic idle_ok);
    job_t j;
    j.kind    = JobGlyph;
    j.reg_idx = '0;
    j.value   = w;
    j.idle_ok = idle_ok;
    glyph_jobs = {glyph_jobs, j};
    glyphs_queued++;
  endtask

  task automatic queue_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    job_t j;
    j.kind    = JobCfg;
    j.reg_idx = idx;
    j.value   = data;
    j.idle_ok = 1'b1;
    glyph_jobs = {glyph_jobs, j};
  endtask

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    mismatches++;
    if (mismatches <= LogCap)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               results_seen, what, got_v, want_v);
  endtask

  // driver: glyph items on the slave stream, register writes only when drained
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    logic nxt_cfg;
    job_t job;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_cfg   = cfg_valid_i;
      if (s_axis_tvalid && s_axis_tready) begin
        placements_due = {placements_due, place_glyph(s_axis_tdata[GlyphW-1:0])};
        glyphs_sent++;
        nxt_valid = 1'b0;
        if (gaps_on && $urandom_range(0, 4) == 0) sender_gap = $urandom_range(1, 10);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegRowHeight: cur_row_height = RowHeightW'(cfg_data_i);
          RegGlyphGap:  cur_gap        = GapW'(cfg_data_i);
          default: ;
        endcase
        nxt_cfg = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (glyph_jobs.size() > 0) begin
          if (glyph_jobs[0].kind == JobGlyph) begin
            job = glyph_jobs.pop_front();
            s_axis_tdata <= InDataW'(job.value);
            nxt_valid = 1'b1;
            gaps_on   = job.idle_ok;
            calm      <= !job.idle_ok;
          end else if (glyphs_sent == results_seen) begin
            job = glyph_jobs.pop_front();
            cfg_index_i <= job.reg_idx;
            cfg_data_i  <= job.value;
            nxt_cfg = 1'b1;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_valid_i   <= nxt_cfg;
    end
  end

  // monitor: checks each result item and paces the master stream
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    logic       rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (placements_due.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(m_axis_tuser), 0);
        end else begin
          want = placements_due.pop_front();
          if (m_axis_tuser != want.st)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want.st));
          if (m_axis_tdata[AtlasIdxW-1:0] != want.atlas)
            report_mismatch("atlas_index", 32'(m_axis_tdata[AtlasIdxW-1:0]), 32'(want.atlas));
          if (m_axis_tdata[AtlasIdxW +: PosW] != want.x)
            report_mismatch("pos_x", 32'(m_axis_tdata[AtlasIdxW +: PosW]), 32'(want.x));
          if (m_axis_tdata[AtlasIdxW + PosW +: PosW] != want.y)
            report_mismatch("pos_y", 32'(m_axis_tdata[AtlasIdxW + PosW +: PosW]),
                            32'(want.y));
          if (m_axis_tdata[OutDataW-1:AtlasIdxW + 2 * PosW] != '0)
            report_mismatch("padding", 32'(m_axis_tdata[OutDataW-1:AtlasIdxW + 2 * PosW]), 0);
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HoldAt) begin
        // long hold so the block backs up into its input
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && (results_seen / 50) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin
    logic [CfgDataW-1:0] rh;
    logic [CfgDataW-1:0] gd;
    int unsigned         len;
    int unsigned         idx;
    cur_row_height = RowHeightRst;
    cur_gap        = GlyphGapRst;
    foreach (shelves_open[a]) begin
      shelves_open[a] = '0;
      atlas_fill[a]   = '0;
    end

    // too wide, exact fits, zero width against full shelves
    queue_glyph(GlyphW'(2047), 1'b1);
    queue_glyph(GlyphW'(1025), 1'b1);
    queue_glyph(GlyphW'(0), 1'b1);
    queue_glyph(GlyphW'(1024), 1'b1);
    queue_glyph(GlyphW'(1022), 1'b1);
    queue_glyph(GlyphW'(0), 1'b1);
    // flat rows use up every shelf slot of the first atlas
    queue_cfg(RegRowHeight, CfgDataW'(0));
    queue_cfg(RegGlyphGap, CfgDataW'(0));
    for (int i = 0; i < 14; i++) queue_glyph(GlyphW'(1024), 1'b1);
    queue_glyph(GlyphW'(0), 1'b1);
    queue_cfg(RegRowHeight, CfgDataW'(1024));
    queue_cfg(RegGlyphGap, CfgDataW'(15));
    queue_glyph(GlyphW'(1024), 1'b1);
    queue_cfg(RegSpareA, CfgDataW'(2047));
    queue_cfg(RegSpareB, CfgDataW'(0));
    queue_cfg(RegRowHeight, CfgDataW'(2047));
    queue_glyph(GlyphW'(1000), 1'b1);
    queue_glyph(GlyphW'(1024), 1'b1);

    idx = 0;
    for (int p = 0; p < PhaseCnt; p++) begin
      case (p)
        0: begin rh = CfgDataW'(64);   gd = CfgDataW'(2);    len = 350; end
        1: begin rh = CfgDataW'(1);    gd = CfgDataW'(15);   len = 300; end
        2: begin
          rh = CfgDataW'($urandom_range(1, 1024));
          gd = CfgDataW'($urandom_range(0, 15));
          len = 300;
        end
        3: begin rh = CfgDataW'(1024); gd = CfgDataW'(0);    len = 250; end
        4: begin rh = CfgDataW'(2047); gd = CfgDataW'(2047); len = 250; end
        default: begin
          rh = CfgDataW'($urandom_range(0, 2047));
          gd = CfgDataW'($urandom_range(0, 2047));
          len = RandomTotal - idx;
        end
      endcase
      queue_cfg(RegRowHeight, rh);
      queue_cfg(RegGlyphGap, gd);
      for (int unsigned i = 0; i < len; i++) begin
        queue_glyph(pick_width(), idx < RandomTotal - CalmTail && (idx / 64) % 3 != 0);
        idx++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (results_seen != glyphs_queued) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (placements_due.size() != 0)
      report_mismatch("results never delivered", 0, placements_due.size());
    if (mismatches == 0) begin
      $display("tb_glyph_atlas_shelf_packer_core: done, clean");
    end else begin
      $display("tb_glyph_atlas_shelf_packer_core: done, errors");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_glyph_atlas_shelf_packer_core: done, errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gasp_pkg.sv
hw/rtl/gasp_ram.sv
hw/rtl/gasp_atlas_tbl.sv
hw/rtl/glyph_atlas_shelf_packer_core.sv
hw/rtl/gasp_checker.sv
tb/tb_glyph_atlas_shelf_packer_core.sv
